/* hdl/uswm_pkg.sv */
// Shared types and constants for the UDP socket wildcard match table.
// Used by uswm_front, uswm_back and the top level; depends on nothing else.
package uswm_pkg;

	// Table geometry
	localparam int TABLE_ENTRIES = 16;
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

	// Stream widths
	localparam int IN_DATA_W  = 104;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 24;
	localparam int QUEUE_DEPTH = 2;

	// Reset value of the ephemeral port base
	localparam logic [15:0] EPHEMERAL_RESET = 16'd49152;
	localparam logic [15:0] PORT_MAX = 16'hFFFF;

	// Operation codes carried on tuser
	localparam logic [1:0] OP_WRITE  = 2'd0;
	localparam logic [1:0] OP_LOOKUP = 2'd1;
	localparam logic [1:0] OP_PORT   = 2'd2;
	localparam logic [1:0] OP_NONE   = 2'd3;

	typedef enum logic [1:0] {
		K_WRITE,
		K_LOOKUP,
		K_PORT,
		K_NOP
	} kind_t;

	typedef enum logic {
		B_IDLE,
		B_SCAN
	} back_state_t;

	// Input tdata layout, lowest field last
	typedef struct packed {
		logic [2:0]  pad;
		logic [15:0] peer_port;
		logic [31:0] peer_addr;
		logic [15:0] local_port_in;
		logic [31:0] local_addr;
		logic        entry_on;
		logic [3:0]  slot;
	} in_data_t;

	// Output tdata layout, lowest field last
	typedef struct packed {
		logic [15:0] free_port;
		logic        port_ok;
		logic [1:0]  hit_level;
		logic [3:0]  hit_slot;
		logic        hit;
	} result_t;

	// One stored socket entry
	typedef struct packed {
		logic [31:0] local_addr;
		logic [15:0] sock_port;
		logic [31:0] peer_addr;
		logic [15:0] peer_port;
	} entry_t;

	// Classified transaction handed from front to back
	typedef struct packed {
		kind_t            kind;
		logic             wr_ok;
		logic [IDX_W-1:0] wr_idx;
		logic             entry_on;
		entry_t           fields;
	} q_item_t;

endpackage

/* hdl/udp_socket_wildcard_match_table.sv */
// Top level of the UDP socket wildcard match table.
// Depends on uswm_pkg, uswm_front and uswm_back.
//
// A stream of operations (tuser = op) writes socket entries, looks up the
// best wildcard match, or searches for the lowest free port at or above the
// ephemeral base set through cfg_we/cfg_wdata. Every operation returns one
// 24-bit result. Operations enter a two-deep queue, so input is taken while
// the back end scans. A lookup reads the table through its single registered
// read port, one entry per cycle while the result output is not stalled. A
// free port search scans the table once per candidate port and restarts on
// the first entry that holds the candidate. A stalled result output holds
// the back end.
module udp_socket_wildcard_match_table import uswm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [15:0]           cfg_wdata,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// slot, entry_on, local_addr, local_port_in, peer_addr, peer_port, zero pad
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// op
	input  logic [IN_USER_W-1:0]  s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// hit, hit_slot, hit_level, port_ok, free_port
	output logic [OUT_DATA_W-1:0] m_axis_tdata
);

	logic    q_valid;
	logic    q_pop;
	q_item_t q_head;

	// Accept and classify
	uswm_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.q_valid       (q_valid),
		.q_head        (q_head),
		.q_pop         (q_pop)
	);

	// Execute against the table
	uswm_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.q_valid       (q_valid),
		.q_head        (q_head),
		.q_pop         (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

/* hdl/uswm_front.sv */
// Front end: accepts input transactions, decodes the operation and queues them.
// Depends on uswm_pkg.
module uswm_front import uswm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// slot, entry_on, local_addr, local_port_in, peer_addr, peer_port, zero pad
	input  logic [IN_DATA_W-1:0] s_axis_tdata,
	// op
	input  logic [IN_USER_W-1:0] s_axis_tuser,
	output logic                 q_valid,
	output q_item_t              q_head,
	input  logic                 q_pop
);

	in_data_t in_d;
	q_item_t  cls;
	logic     push;

	q_item_t  fifo_q [QUEUE_DEPTH];
	logic     wr_ptr_q;
	logic     rd_ptr_q;
	logic [1:0] cnt_q;

	assign in_d = in_data_t'(s_axis_tdata);

	// Decode the operation and check the slot range
	always_comb begin
		cls.fields.local_addr = in_d.local_addr;
		cls.fields.sock_port  = in_d.local_port_in;
		cls.fields.peer_addr  = in_d.peer_addr;
		cls.fields.peer_port  = in_d.peer_port;
		cls.entry_on = in_d.entry_on;
		cls.wr_idx   = IDX_W'(in_d.slot);
		cls.wr_ok    = (32'(in_d.slot) < TABLE_ENTRIES);
		unique case (s_axis_tuser)
			OP_WRITE:  cls.kind = K_WRITE;
			OP_LOOKUP: cls.kind = K_LOOKUP;
			OP_PORT:   cls.kind = K_PORT;
			OP_NONE:   cls.kind = K_NOP;
			default:   cls.kind = K_NOP;
		endcase
	end

	assign s_axis_tready = (cnt_q != 2'(QUEUE_DEPTH));
	assign push          = s_axis_tvalid && s_axis_tready;
	assign q_valid       = (cnt_q != 2'd0);
	assign q_head        = fifo_q[rd_ptr_q];

	// Advance queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (q_pop) rd_ptr_q <= ~rd_ptr_q;
			if (push && !q_pop) cnt_q <= cnt_q + 2'd1;
			else if (!push && q_pop) cnt_q <= cnt_q - 2'd1;
		end
	end

	// Store the classified transaction
	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_ptr_q] <= cls;
	end

endmodule

/* hdl/uswm_back.sv */
// Back end: socket table, entry scan sequencer and result register.
// Depends on uswm_pkg; takes queued transactions from uswm_front.
module uswm_back import uswm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [15:0]           cfg_wdata,
	input  logic                  q_valid,
	input  q_item_t               q_head,
	output logic                  q_pop,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata
);

	localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_ENTRIES - 1);
	localparam logic [CNT_W-1:0] CNT_TOTAL = CNT_W'(TABLE_ENTRIES);

	back_state_t state_q, state_d;

	entry_t mem_q [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [15:0] base_q;

	kind_t            scan_kind_q;
	entry_t           qry_q;
	logic [CNT_W-1:0] issue_cnt_q;
	logic             chk_vld_s1;
	logic [IDX_W-1:0] idx_s1;
	entry_t           rd_data_s1;
	logic             best_vld_q;
	logic [1:0]       best_lvl_q;
	logic [IDX_W-1:0] best_idx_q;
	logic [15:0]      cand_q;

	logic            out_valid_q;
	result_t         out_data_q;

	logic go, start, finish, do_wr, issue, restart;
	result_t fin_data;
	logic [IDX_W-1:0] rd_addr;

	logic ent_valid, lp_eq, la_eq, pa_eq, pp_eq, la_ok, pa_ok, pp_ok, match;
	logic [1:0] lvl;
	logic take, conflict, is_last;
	logic [1:0] best_nxt_lvl;
	logic [IDX_W-1:0] best_nxt_idx;
	logic best_nxt_vld;

	assign go      = !out_valid_q || m_axis_tready;
	assign rd_addr = issue_cnt_q[IDX_W-1:0];

	// Compare the entry held in the read register with the query
	always_comb begin
		ent_valid = valid_q[idx_s1];
		lp_eq = (rd_data_s1.sock_port == qry_q.sock_port);
		la_eq = (rd_data_s1.local_addr == qry_q.local_addr);
		pa_eq = (rd_data_s1.peer_addr == qry_q.peer_addr);
		pp_eq = (rd_data_s1.peer_port == qry_q.peer_port);
		la_ok = la_eq || (rd_data_s1.local_addr == 32'd0) || (qry_q.local_addr == 32'd0);
		pa_ok = pa_eq || (rd_data_s1.peer_addr == 32'd0) || (qry_q.peer_addr == 32'd0);
		pp_ok = pp_eq || (rd_data_s1.peer_port == 16'd0) || (qry_q.peer_port == 16'd0);
		match = chk_vld_s1 && ent_valid && lp_eq && la_ok && pa_ok && pp_ok;
		lvl   = 2'(la_eq) + 2'(pa_eq) + 2'(pp_eq);
		take  = match && (!best_vld_q || (lvl > best_lvl_q));
		best_nxt_vld = best_vld_q || take;
		best_nxt_lvl = take ? lvl : best_lvl_q;
		best_nxt_idx = take ? idx_s1 : best_idx_q;
		conflict = chk_vld_s1 && ent_valid && (rd_data_s1.sock_port == cand_q);
		is_last  = chk_vld_s1 && (idx_s1 == LAST_IDX);
	end

	// Sequencer outputs
	always_comb begin
		q_pop    = 1'b0;
		start    = 1'b0;
		finish   = 1'b0;
		do_wr    = 1'b0;
		issue    = 1'b0;
		restart  = 1'b0;
		fin_data = '0;
		unique case (state_q)
			B_IDLE: begin
				if (q_valid && go) begin
					q_pop = 1'b1;
					if (q_head.kind == K_LOOKUP || q_head.kind == K_PORT) begin
						start = 1'b1;
					end else begin
						finish = 1'b1;
						do_wr  = (q_head.kind == K_WRITE) && q_head.wr_ok;
					end
				end
			end
			B_SCAN: begin
				if (go) begin
					issue = (issue_cnt_q < CNT_TOTAL);
					if (scan_kind_q == K_LOOKUP) begin
						if (is_last) begin
							finish = 1'b1;
							fin_data.hit = best_nxt_vld;
							if (best_nxt_vld) begin
								fin_data.hit_slot  = 4'(best_nxt_idx);
								fin_data.hit_level = best_nxt_lvl;
							end
						end
					end else if (conflict) begin
						// Port taken: try the next one, or give up at the top
						if (cand_q == PORT_MAX) finish = 1'b1;
						else restart = 1'b1;
					end else if (is_last) begin
						finish = 1'b1;
						fin_data.port_ok   = 1'b1;
						fin_data.free_port = cand_q;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE:  if (start) state_d = B_SCAN;
			B_SCAN:  if (finish) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			valid_q     <= '0;
			base_q      <= EPHEMERAL_RESET;
			issue_cnt_q <= '0;
			chk_vld_s1  <= 1'b0;
			best_vld_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) base_q <= cfg_wdata;
			if (do_wr) valid_q[q_head.wr_idx] <= q_head.entry_on;
			if (start) begin
				issue_cnt_q <= '0;
				chk_vld_s1  <= 1'b0;
				best_vld_q  <= 1'b0;
			end else if (state_q == B_SCAN && go) begin
				chk_vld_s1 <= issue && !restart && !finish;
				if (restart) issue_cnt_q <= '0;
				else if (issue) issue_cnt_q <= issue_cnt_q + CNT_W'(1);
				if (take) best_vld_q <= 1'b1;
			end
			if (finish) out_valid_q <= 1'b1;
			else if (m_axis_tready) out_valid_q <= 1'b0;
		end
	end

	// Payload registers of the scan
	always_ff @(posedge clk) begin
		if (start) begin
			scan_kind_q <= q_head.kind;
			qry_q       <= q_head.fields;
			cand_q      <= base_q;
		end else if (state_q == B_SCAN && go) begin
			if (take) begin
				best_lvl_q <= lvl;
				best_idx_q <= idx_s1;
			end
			if (restart) cand_q <= cand_q + 16'd1;
		end
		if (finish) out_data_q <= fin_data;
	end

	// Socket table: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (do_wr) mem_q[q_head.wr_idx] <= q_head.fields;
		if (issue) begin
			rd_data_s1 <= mem_q[rd_addr];
			idx_s1     <= rd_addr;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_DATA_W'(out_data_q);

endmodule
